/* sv/ttip_pkg.sv */
`default_nettype none
package ttip_pkg;

	// default widths of the converted value and the consumed count
	localparam int VALUE_WIDTH_DEF = 64;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int CHAR_W   = 8;
	localparam int BASE_W   = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = BASE_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

	// radix codes
	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

	localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;
	localparam logic              SIGNED_RESET = 1'b1;

	// character codes
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEAD   = 3'd1,
		PH_SIGNED = 3'd2,
		PH_ZERO   = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

	// control part of the conversion state
	typedef struct packed {
		phase_t            phase;
		logic              neg;
		logic [BASE_W-1:0] base;
		logic              seen;
	} ctl_t;

	typedef struct packed {
		logic              ok;
		logic [BASE_W-1:0] val;
	} digit_t;

	// map a character to its digit value, 0-9 then a-z / A-Z as 10..35
	function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
		digit_t d;
		d.ok  = 1'b1;
		d.val = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.val = BASE_W'(c - CH_ZERO);
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d.val = BASE_W'(c - CH_LO_A + 8'd10);
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d.val = BASE_W'(c - CH_UP_A + 8'd10);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

/* sv/ttip_step.sv */
`default_nettype none
module ttip_step import ttip_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic [CHAR_W-1:0]      char_code,
	input  wire logic                   first_char,
	input  wire logic [BASE_W-1:0]      number_base,
	input  wire logic                   signed_mode,
	input  wire ctl_t                   ctl_cur,
	input  wire logic [VALUE_WIDTH-1:0] acc_cur,
	input  wire logic [COUNT_WIDTH-1:0] cnt_cur,
	output ctl_t                        ctl_nxt,
	output logic [VALUE_WIDTH-1:0]      acc_nxt,
	output logic [COUNT_WIDTH-1:0]      cnt_nxt,
	output logic                        emit,
	output logic [VALUE_WIDTH-1:0]      value
);

	ctl_t                   ctl_start;
	logic [VALUE_WIDTH-1:0] acc_start;
	logic [COUNT_WIDTH-1:0] cnt_start;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic                   is_space;
	logic                   is_sign;
	digit_t                 dig;

	// a first character restarts the conversion state
	always_comb begin
		if (first_char) begin
			ctl_start.phase = PH_LEAD;
			ctl_start.neg   = 1'b0;
			ctl_start.base  = number_base;
			ctl_start.seen  = 1'b0;
			acc_start       = '0;
			cnt_start       = '0;
		end else begin
			ctl_start = ctl_cur;
			acc_start = acc_cur;
			cnt_start = cnt_cur;
		end
	end

	// saturating count of consumed characters
	assign cnt_inc = (&cnt_start) ? cnt_start : cnt_start + 1'b1;

	assign is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
	assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS && signed_mode);
	assign dig      = digit_of(char_code);

	// next state: walk lead, sign, prefix and digit phases for this character
	always_comb begin
		logic done;
		done    = 1'b0;
		ctl_nxt = ctl_start;
		acc_nxt = acc_start;
		cnt_nxt = cnt_start;
		emit    = 1'b0;

		if (ctl_nxt.phase == PH_IDLE) begin
			done = 1'b1;
		end

		if (!done && ctl_nxt.phase == PH_LEAD) begin
			if (is_space) begin
				cnt_nxt = cnt_inc;
				done    = 1'b1;
			end else if (is_sign) begin
				ctl_nxt.neg   = (char_code == CH_MINUS);
				cnt_nxt       = cnt_inc;
				ctl_nxt.phase = PH_SIGNED;
				done          = 1'b1;
			end else begin
				ctl_nxt.phase = PH_SIGNED;
			end
		end

		if (!done && ctl_nxt.phase == PH_SIGNED) begin
			if (char_code == CH_ZERO &&
			    (ctl_nxt.base == BASE_AUTO || ctl_nxt.base == BASE_HEX)) begin
				cnt_nxt       = cnt_inc;
				ctl_nxt.phase = PH_ZERO;
				done          = 1'b1;
			end else begin
				if (ctl_nxt.base == BASE_AUTO) begin
					ctl_nxt.base = BASE_DEC;
				end
				ctl_nxt.phase = PH_DIGITS;
			end
		end else if (!done && ctl_nxt.phase == PH_ZERO) begin
			if (char_code == CH_LO_X || char_code == CH_UP_X) begin
				ctl_nxt.base  = BASE_HEX;
				cnt_nxt       = cnt_inc;
				ctl_nxt.phase = PH_DIGITS;
				done          = 1'b1;
			end else begin
				// the lone zero was a digit after all
				ctl_nxt.seen = 1'b1;
				if (ctl_nxt.base == BASE_AUTO) begin
					ctl_nxt.base = BASE_OCT;
				end
				ctl_nxt.phase = PH_DIGITS;
			end
		end

		if (!done) begin
			if (dig.ok && dig.val < ctl_nxt.base) begin
				acc_nxt      = acc_start * VALUE_WIDTH'(ctl_nxt.base) + VALUE_WIDTH'(dig.val);
				ctl_nxt.seen = 1'b1;
				cnt_nxt      = cnt_inc;
			end else begin
				emit          = 1'b1;
				ctl_nxt.phase = PH_IDLE;
			end
		end
	end

	// result value, negated in two's complement after a minus
	assign value = ctl_start.neg ? ('0 - acc_start) : acc_start;

endmodule
`default_nettype wire

/* sv/text_to_integer_parser.sv */
// Text to integer converter, one character per beat.
// Slave channel: s_tdata[7:0] = char_code, s_tuser = first_char. A beat with
// first_char set starts a new string; beats before the first string or after
// a result are dropped until the next first_char.
// Master channel: one beat per string, sent for the first character that
// cannot continue the number (NUL, a non-digit, or a digit not below the radix).
// Configuration: cfg_wr_en/cfg_index/cfg_data, index 0 = number_base,
// index 1 = signed_mode; write only while no string is in flight.
// Throughput: one character per cycle unless a second result is held back
// (see Stall). The per-character step is a value-by-radix multiply-add that
// closes on the accumulator register.
// Result path: the stopping character is captured in the input register,
// and its result is then loaded into the output register that drives
// m_tvalid; that load waits while an earlier result is still held.
// Reset: clears the valid flags and conversion state; number_base returns
// to 10 and signed_mode to 1. No clearing pass is needed.
// Stall: when a result waits in the output register, the input register is
// still refilled; only a character that would produce a second result holds
// until the output register frees up.
`default_nettype none
module text_to_integer_parser import ttip_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// slave channel
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,  // [7:0] char_code
	input  wire logic                   s_tuser,  // [0] first_char
	// master channel
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// from bit 0: value, consumed, any_digit, zero fill
	output logic [((VALUE_WIDTH + COUNT_WIDTH + 1 + 7) / 8) * 8 - 1:0] m_tdata,
	// configuration write port
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int TDATA_W = ((VALUE_WIDTH + COUNT_WIDTH + 1 + 7) / 8) * 8;

	logic [BASE_W-1:0]      number_base_q;
	logic                   signed_mode_q;

	logic                   valid_s1;
	logic [CHAR_W-1:0]      char_s1;
	logic                   first_s1;

	ctl_t                   ctl_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	ctl_t                   ctl_nxt;
	logic [VALUE_WIDTH-1:0] acc_nxt;
	logic [COUNT_WIDTH-1:0] cnt_nxt;
	logic                   emit;
	logic [VALUE_WIDTH-1:0] value_nxt;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [COUNT_WIDTH-1:0] consumed_q;
	logic                   any_digit_q;

	logic                   advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
			signed_mode_q <= SIGNED_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NUMBER_BASE: number_base_q <= cfg_data;
				REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// advance the input register unless its result would collide with a held one
	assign advance  = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1  <= s_tdata[CHAR_W-1:0];
			first_s1 <= s_tuser;
		end
	end

	ttip_step #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.char_code   (char_s1),
		.first_char  (first_s1),
		.number_base (number_base_q),
		.signed_mode (signed_mode_q),
		.ctl_cur     (ctl_q),
		.acc_cur     (acc_q),
		.cnt_cur     (cnt_q),
		.ctl_nxt     (ctl_nxt),
		.acc_nxt     (acc_nxt),
		.cnt_nxt     (cnt_nxt),
		.emit        (emit),
		.value       (value_nxt)
	);

	// conversion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase <= PH_IDLE;
			ctl_q.neg   <= 1'b0;
			ctl_q.base  <= '0;
			ctl_q.seen  <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
			acc_q <= acc_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	// output register: load a result beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q     <= value_nxt;
			consumed_q  <= cnt_nxt;
			any_digit_q <= ctl_nxt.seen;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'({any_digit_q, consumed_q, value_q});

endmodule
`default_nettype wire
